// File: hw/rtl/uvsig_pkg.sv
package uvsig_pkg;

    localparam int MAX_DIVISIONS = 256;
    localparam int DIV_W         = 9;
    localparam int CNT_W         = 8;
    localparam int IDX_W         = 16;

    // configuration register indexes
    localparam logic CFG_VDIV = 1'b0;
    localparam logic CFG_HDIV = 1'b1;

    // sequence sections
    localparam logic [1:0] PH_BAND = 2'd0;
    localparam logic [1:0] PH_CAP  = 2'd1;
    localparam logic [1:0] PH_WRAP = 2'd2;

    localparam logic [DIV_W-1:0] DIV_MIN = DIV_W'(3);
    localparam logic [DIV_W-1:0] DIV_MAX = DIV_W'(MAX_DIVISIONS);

    // one triangle to be formed
    typedef struct packed {
        logic [1:0]       phase;
        logic             half;
        logic [CNT_W-1:0] band;
        logic [CNT_W-1:0] col;
        logic [CNT_W-1:0] col1;
        logic             last;
    } tri_desc_t;

    function automatic logic [DIV_W-1:0] clamp_div(input logic [DIV_W-1:0] v);
        logic [DIV_W-1:0] r;
        begin
            if (v < DIV_MIN)
            begin
                r = DIV_MIN;
            end
            else if (v > DIV_MAX)
            begin
                r = DIV_MAX;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

// File: hw/rtl/uvsig_seq.sv
module uvsig_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    input  logic [uvsig_pkg::DIV_W-1:0]   vdiv,
    input  logic [uvsig_pkg::DIV_W-1:0]   hdiv,
    output logic                          desc_valid,
    output uvsig_pkg::tri_desc_t          desc,
    input  logic                          desc_ready
);
    import uvsig_pkg::*;

    logic [CNT_W-1:0] band_reg, band_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [1:0]       phase_reg, phase_next;
    logic             half_reg, half_next;
    logic             dvalid_reg;
    tri_desc_t        desc_reg, desc_next;

    logic [CNT_W-1:0] band_cur, col_cur, col1;
    logic [1:0]       phase_cur;
    logic             half_cur;
    logic             col_wrap, cap_end, band_end, accept;

    assign in_ready   = !dvalid_reg || desc_ready;
    assign accept     = in_valid && in_ready;
    assign desc_valid = dvalid_reg;
    assign desc       = desc_reg;

    always_comb
    begin
        // restart behaves as a cleared sequence for this request
        band_cur  = restart ? '0 : band_reg;
        col_cur   = restart ? '0 : col_reg;
        phase_cur = restart ? PH_BAND : phase_reg;
        half_cur  = restart ? 1'b0 : half_reg;

        col_wrap = {1'b0, col_cur} >= (hdiv - DIV_W'(1));
        cap_end  = {1'b0, col_cur} >= (hdiv - DIV_W'(2));
        band_end = {1'b0, band_cur} >= (vdiv - DIV_W'(3));
        col1     = col_wrap ? '0 : col_cur + CNT_W'(1);

        band_next  = band_cur;
        col_next   = col_cur;
        phase_next = phase_cur;
        half_next  = !half_cur;

        desc_next.phase = phase_cur;
        desc_next.half  = half_cur;
        desc_next.band  = band_cur;
        desc_next.col   = col_cur;
        desc_next.col1  = col1;
        desc_next.last  = 1'b0;

        case (phase_cur)
            PH_BAND:
            begin
                if (half_cur)
                begin
                    if (col_wrap)
                    begin
                        col_next = '0;
                        if (band_end)
                        begin
                            band_next  = '0;
                            phase_next = PH_CAP;
                        end
                        else
                        begin
                            band_next = band_cur + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col1;
                    end
                end
            end
            PH_CAP:
            begin
                if (half_cur)
                begin
                    if (cap_end)
                    begin
                        col_next   = '0;
                        phase_next = PH_WRAP;
                    end
                    else
                    begin
                        col_next = col_cur + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                if (half_cur)
                begin
                    desc_next.last = 1'b1;
                    band_next      = '0;
                    col_next       = '0;
                    phase_next     = PH_BAND;
                    half_next      = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg   <= '0;
            col_reg    <= '0;
            phase_reg  <= PH_BAND;
            half_reg   <= 1'b0;
            dvalid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                band_reg   <= band_next;
                col_reg    <= col_next;
                phase_reg  <= phase_next;
                half_reg   <= half_next;
                dvalid_reg <= 1'b1;
            end
            else if (desc_ready)
            begin
                dvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            desc_reg <= desc_next;
        end
    end

endmodule

// File: hw/rtl/uvsig_calc.sv
module uvsig_calc (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [uvsig_pkg::DIV_W-1:0]   vdiv,
    input  logic [uvsig_pkg::DIV_W-1:0]   hdiv,
    input  logic                          desc_valid,
    input  uvsig_pkg::tri_desc_t          desc,
    output logic                          desc_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [uvsig_pkg::IDX_W-1:0]   first_index,
    output logic [uvsig_pkg::IDX_W-1:0]   second_index,
    output logic [uvsig_pkg::IDX_W-1:0]   third_index,
    output logic                          last_triangle
);
    import uvsig_pkg::*;

    logic [2*DIV_W-1:0]       north_prod, sring_prod;
    logic [CNT_W+DIV_W-1:0]   ring_prod;
    logic [IDX_W-1:0]         north_reg, sring_reg;
    logic [IDX_W-1:0]         ring_base_reg;
    tri_desc_t                bdesc_reg;
    logic                     bvalid_reg, ovalid_reg;
    logic                     adv_b, adv_c;

    logic [IDX_W-1:0] h16, c16, c1_16, r1, south;
    logic [IDX_W-1:0] a_next, b_next, d_next;
    logic [IDX_W-1:0] a_reg, b_reg, d_reg;
    logic             last_reg;

    assign adv_c      = !ovalid_reg || out_ready;
    assign adv_b      = !bvalid_reg || adv_c;
    assign desc_ready = adv_b;

    // pole and south ring bases follow the configuration
    assign north_prod = {{DIV_W{1'b0}}, vdiv - DIV_W'(1)} * {{DIV_W{1'b0}}, hdiv};
    assign sring_prod = {{DIV_W{1'b0}}, vdiv - DIV_W'(2)} * {{DIV_W{1'b0}}, hdiv};
    assign ring_prod  = {{DIV_W{1'b0}}, desc.band} * {{CNT_W{1'b0}}, hdiv};

    always_ff @(posedge clk)
    begin
        north_reg <= north_prod[IDX_W-1:0];
        sring_reg <= sring_prod[IDX_W-1:0];
    end

    always_comb
    begin
        h16    = {{(IDX_W-DIV_W){1'b0}}, hdiv};
        c16    = {{(IDX_W-CNT_W){1'b0}}, bdesc_reg.col};
        c1_16  = {{(IDX_W-CNT_W){1'b0}}, bdesc_reg.col1};
        r1     = ring_base_reg + h16;
        south  = north_reg + IDX_W'(1);
        a_next = '0;
        b_next = '0;
        d_next = '0;
        case (bdesc_reg.phase)
            PH_BAND:
            begin
                if (!bdesc_reg.half)
                begin
                    a_next = ring_base_reg + c16;
                    b_next = r1 + c16;
                    d_next = ring_base_reg + c1_16;
                end
                else
                begin
                    a_next = ring_base_reg + c1_16;
                    b_next = r1 + c16;
                    d_next = r1 + c1_16;
                end
            end
            PH_CAP:
            begin
                if (!bdesc_reg.half)
                begin
                    a_next = north_reg;
                    b_next = c16;
                    d_next = c1_16;
                end
                else
                begin
                    a_next = sring_reg + c1_16;
                    b_next = sring_reg + c16;
                    d_next = south;
                end
            end
            default:
            begin
                if (!bdesc_reg.half)
                begin
                    a_next = north_reg;
                    b_next = h16 - IDX_W'(1);
                    d_next = '0;
                end
                else
                begin
                    a_next = sring_reg;
                    b_next = sring_reg + h16 - IDX_W'(1);
                    d_next = south;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bvalid_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (adv_b)
            begin
                bvalid_reg <= desc_valid;
            end
            if (adv_c)
            begin
                ovalid_reg <= bvalid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_b && desc_valid)
        begin
            bdesc_reg     <= desc;
            ring_base_reg <= ring_prod[IDX_W-1:0];
        end
        if (adv_c && bvalid_reg)
        begin
            a_reg    <= a_next;
            b_reg    <= b_next;
            d_reg    <= d_next;
            last_reg <= bdesc_reg.last;
        end
    end

    assign out_valid     = ovalid_reg;
    assign first_index   = a_reg;
    assign second_index  = b_reg;
    assign third_index   = d_reg;
    assign last_triangle = last_reg;

endmodule

// File: hw/rtl/uv_sphere_index_generator.sv
// UV sphere triangle index generator.
// An accepted request's triangle passes the descriptor, ring-base and output registers.
// Throughput: one triangle per cycle; the only limit is out_ready back-pressure.
// Reset (rst_n, async active low): sequence restarts at the first band
// triangle, pipeline empties, both division registers return to 3.
module uv_sphere_index_generator (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_write,
    input  logic                          cfg_index,
    input  logic [uvsig_pkg::DIV_W-1:0]   cfg_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          restart,
    // triangle channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [uvsig_pkg::IDX_W-1:0]   first_index,
    output logic [uvsig_pkg::IDX_W-1:0]   second_index,
    output logic [uvsig_pkg::IDX_W-1:0]   third_index,
    output logic                          last_triangle
);
    import uvsig_pkg::*;

    // Division registers, held raw and clamped to 3..MAX_DIVISIONS on use.
    logic [DIV_W-1:0] vdiv_reg, hdiv_reg;
    logic [DIV_W-1:0] vdiv_c, hdiv_c;

    // Sequencer to index datapath hand-off.
    logic      desc_valid, desc_ready;
    tri_desc_t desc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vdiv_reg <= DIV_MIN;
            hdiv_reg <= DIV_MIN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_VDIV: vdiv_reg <= cfg_data;
                CFG_HDIV: hdiv_reg <= cfg_data;
                default:  vdiv_reg <= vdiv_reg;
            endcase
        end
    end

    assign vdiv_c = clamp_div(vdiv_reg);
    assign hdiv_c = clamp_div(hdiv_reg);

    // Stage 1: band/column/section counters walk the mesh, one triangle
    // per accepted request, and register a triangle descriptor.
    uvsig_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .restart    (restart),
        .vdiv       (vdiv_c),
        .hdiv       (hdiv_c),
        .desc_valid (desc_valid),
        .desc       (desc),
        .desc_ready (desc_ready)
    );

    // Stage 2: ring base = band * columns (one 8x9 multiply, registered).
    // Stage 3: ring/pole offsets added and selected into the output register.
    uvsig_calc u_calc (
        .clk           (clk),
        .rst_n         (rst_n),
        .vdiv          (vdiv_c),
        .hdiv          (hdiv_c),
        .desc_valid    (desc_valid),
        .desc          (desc),
        .desc_ready    (desc_ready),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .first_index   (first_index),
        .second_index  (second_index),
        .third_index   (third_index),
        .last_triangle (last_triangle)
    );

endmodule

// File: hw/rtl/uvsig_checker.sv
module uvsig_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] first_index,
    input logic [15:0] second_index,
    input logic [15:0] third_index,
    input logic        last_triangle
);

    // a stalled triangle holds its indices
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(first_index)
            && $stable(second_index) && $stable(third_index))
        else $error("stalled triangle changed");

    // requests are only refused while a triangle waits at the output
    a_ready_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("request refused with empty output");

    // south wrap triangle: south pole sits two past the last south ring vertex
    a_last_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_triangle |-> third_index == 16'(second_index + 16'd2))
        else $error("last triangle does not close on the south pole");

    // an edge seen in reset leaves the output empty
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind uv_sphere_index_generator uvsig_checker u_uvsig_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .first_index   (first_index),
    .second_index  (second_index),
    .third_index   (third_index),
    .last_triangle (last_triangle)
);

// File: verif/uv_sphere_index_generator_tb.sv
`timescale 1ns / 1ps

import uvsig_pkg::*;

typedef struct packed {
    logic [IDX_W-1:0] first_idx;
    logic [IDX_W-1:0] second_idx;
    logic [IDX_W-1:0] third_idx;
    logic             is_last;
} triangle_t;

class mesh_scoreboard;
    logic [DIV_W-1:0] vdiv;
    logic [DIV_W-1:0] hdiv;
    logic [CNT_W-1:0] band;
    logic [CNT_W-1:0] col;
    logic [1:0]       section;
    bit               second_half;
    triangle_t        expected_tris[$];
    int               errors;
    int               checked;
    int               meshes;

    function new();
        vdiv = DIV_W'(3);
        hdiv = DIV_W'(3);
        errors = 0;
        checked = 0;
        meshes = 0;
        restart_mesh();
    endfunction

    function void restart_mesh();
        band = '0;
        col = '0;
        section = PH_BAND;
        second_half = 1'b0;
    endfunction

    function void set_divisions(logic [DIV_W-1:0] v, logic [DIV_W-1:0] h);
        vdiv = v;
        hdiv = h;
    endfunction

    function int unsigned clamp_divisions(logic [DIV_W-1:0] d);
        if (d < 3)
        begin
            return 3;
        end
        if (d > MAX_DIVISIONS)
        begin
            return MAX_DIVISIONS;
        end
        return d;
    endfunction

    // next triangle of the mesh walk; advances the counters
    function triangle_t next_triangle(bit restart_req);
        int unsigned v, h, north, south, s_ring, r0, r1, c, c1;
        triangle_t t;
        v = clamp_divisions(vdiv);
        h = clamp_divisions(hdiv);
        north = (v - 1) * h;
        south = north + 1;
        s_ring = (v - 2) * h;
        t = '0;
        if (restart_req)
        begin
            restart_mesh();
        end
        c = col;
        c1 = (c >= h - 1) ? 0 : c + 1;
        r0 = band * h;
        r1 = r0 + h;
        case (section)
            PH_BAND:
            begin
                if (!second_half)
                begin
                    t.first_idx = IDX_W'(r0 + c);
                    t.second_idx = IDX_W'(r1 + c);
                    t.third_idx = IDX_W'(r0 + c1);
                    second_half = 1'b1;
                end
                else
                begin
                    t.first_idx = IDX_W'(r0 + c1);
                    t.second_idx = IDX_W'(r1 + c);
                    t.third_idx = IDX_W'(r1 + c1);
                    second_half = 1'b0;
                    if (c >= h - 1)
                    begin
                        col = '0;
                        if (band >= v - 3)
                        begin
                            band = '0;
                            section = PH_CAP;
                        end
                        else
                        begin
                            band = band + 1'b1;
                        end
                    end
                    else
                    begin
                        col = col + 1'b1;
                    end
                end
            end
            PH_CAP:
            begin
                if (!second_half)
                begin
                    t.first_idx = IDX_W'(north);
                    t.second_idx = IDX_W'(c);
                    t.third_idx = IDX_W'(c1);
                    second_half = 1'b1;
                end
                else
                begin
                    t.first_idx = IDX_W'(s_ring + c1);
                    t.second_idx = IDX_W'(s_ring + c);
                    t.third_idx = IDX_W'(south);
                    second_half = 1'b0;
                    if (c >= h - 2)
                    begin
                        col = '0;
                        section = PH_WRAP;
                    end
                    else
                    begin
                        col = col + 1'b1;
                    end
                end
            end
            default:
            begin
                if (!second_half)
                begin
                    t.first_idx = IDX_W'(north);
                    t.second_idx = IDX_W'(h - 1);
                    t.third_idx = '0;
                    second_half = 1'b1;
                end
                else
                begin
                    t.first_idx = IDX_W'(s_ring);
                    t.second_idx = IDX_W'(s_ring + h - 1);
                    t.third_idx = IDX_W'(south);
                    t.is_last = 1'b1;
                    restart_mesh();
                end
            end
        endcase
        return t;
    endfunction

    function void note_request(bit restart_req);
        expected_tris.insert(expected_tris.size(), next_triangle(restart_req));
    endfunction

    function int pending();
        return expected_tris.size();
    endfunction

    function void check_triangle(triangle_t got);
        triangle_t exp_tri;
        if (expected_tris.size() == 0)
        begin
            $error("triangle %0d/%0d/%0d arrived with no request pending",
                   got.first_idx, got.second_idx, got.third_idx);
            errors++;
            return;
        end
        exp_tri = expected_tris.pop_front();
        checked++;
        if (got.first_idx !== exp_tri.first_idx)
        begin
            $error("first_index: expected %0d, got %0d", exp_tri.first_idx, got.first_idx);
            errors++;
        end
        if (got.second_idx !== exp_tri.second_idx)
        begin
            $error("second_index: expected %0d, got %0d", exp_tri.second_idx, got.second_idx);
            errors++;
        end
        if (got.third_idx !== exp_tri.third_idx)
        begin
            $error("third_index: expected %0d, got %0d", exp_tri.third_idx, got.third_idx);
            errors++;
        end
        if (got.is_last !== exp_tri.is_last)
        begin
            $error("last_triangle: expected %0d, got %0d", exp_tri.is_last, got.is_last);
            errors++;
        end
        else if (exp_tri.is_last)
        begin
            meshes++;
        end
    endfunction
endclass

module uv_sphere_index_generator_tb;

    // cycles with no transfer on either channel before the run is abandoned;
    // far above the longest receiver stall or sender gap
    localparam int IDLE_LIMIT   = 2000;
    // pipeline depth is 3; leave some margin before touching the registers
    localparam int SETTLE_CYCLES = 8;
    localparam int RAND_PHASES   = 16;
    localparam int PHASE_ITEMS   = 55;

    // receiver stall modes
    localparam int RX_STREAM = 0;   // always ready
    localparam int RX_LIGHT  = 1;   // ready with probability 3/4
    localparam int RX_HEAVY  = 2;   // ready with probability 1/4
    localparam int RX_BURSTY = 3;   // ready toggles after random holds

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic                 cfg_index = CFG_VDIV;
    logic [DIV_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 restart = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [IDX_W-1:0]     first_index;
    logic [IDX_W-1:0]     second_index;
    logic [IDX_W-1:0]     third_index;
    logic                 last_triangle;

    mesh_scoreboard sb = new();

    int idle_cycles = 0;
    int burst_left = 0;
    int restarts_sent = 0;
    int settings_used = 1;   // reset setting counts
    int stall_mode = RX_STREAM;
    int mode_left = 0;
    int hold_left = 0;

    uv_sphere_index_generator uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .first_index   (first_index),
        .second_index  (second_index),
        .third_index   (third_index),
        .last_triangle (last_triangle)
    );

    initial
    begin
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Both channels are sampled at the falling edge: everything was driven
    // at the previous rising edge, so the values are settled and the
    // transfer (if any) happens at the next rising edge. Requests are noted
    // before results are checked so a fast path can never outrun the model.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sb.note_request(restart);
            end
            if (out_valid && out_ready)
            begin
                sb.check_triangle('{first_index, second_index, third_index, last_triangle});
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Receiver back-pressure: the mode changes after a random hold so
    // stalls land on every phase of the mesh walk, with free-flowing
    // stretches in between.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                stall_mode <= $urandom_range(RX_STREAM, RX_BURSTY);
                mode_left <= $urandom_range(50, 300);
            end
            else
            begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                RX_STREAM: out_ready <= 1'b1;
                RX_LIGHT:  out_ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:  out_ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (hold_left == 0)
                    begin
                        out_ready <= ~out_ready;
                        hold_left <= $urandom_range(1, 16);
                    end
                    else
                    begin
                        hold_left <= hold_left - 1;
                    end
                end
            endcase
        end
    end

    // Watchdog: nothing moving for too long means a hang.
    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(negedge clk);
        end
        $display("Some tests failed");
        $finish;
    end

    // One request; the sender runs in bursts and drops valid for a random
    // gap between them. Valid is never lowered while a request is pending.
    task automatic send_request(input bit restart_req);
        int gap;
        bit taken;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 12);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        if (restart_req)
        begin
            restarts_sent++;
        end
        in_valid <= 1'b1;
        restart <= restart_req;
        do
        begin
            @(negedge clk);
            taken = in_valid && in_ready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // wait for every triangle in flight, then let the pipeline settle
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers change only while idle. The walk counters keep their
    // values, so a new setting often lands mid-mesh.
    task automatic set_divisions(input logic [DIV_W-1:0] v, input logic [DIV_W-1:0] h);
        drain_pipeline();
        cfg_write <= 1'b1;
        cfg_index <= CFG_VDIV;
        cfg_data <= v;
        @(posedge clk);
        cfg_index <= CFG_HDIV;
        cfg_data <= h;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_divisions(v, h);
        settings_used++;
    endtask

    initial
    begin
        logic [DIV_W-1:0] v;
        logic [DIV_W-1:0] h;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: the reset setting (3 x 3) walks one whole mesh of
        // 12 triangles, wraps into the next one, then restarts land
        // mid-walk and back to back.
        repeat (13) send_request(1'b0);
        send_request(1'b1);
        repeat (4) send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);

        // largest sphere, restarted at once: top of the index range
        set_divisions(DIV_W'(256), DIV_W'(256));
        send_request(1'b1);
        repeat (3) send_request(1'b0);

        // Random phases: the first few pin the extremes and the clamped
        // out-of-range codes, the rest are mostly small spheres so that
        // whole meshes complete many times over.
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:       begin v = DIV_W'(0);   h = DIV_W'(511); end
                1:       begin v = DIV_W'(3);   h = DIV_W'(3);   end
                2:       begin v = DIV_W'(257); h = DIV_W'(2);   end
                3:       begin v = DIV_W'(1);   h = DIV_W'(256); end
                4:       begin v = DIV_W'(256); h = DIV_W'(4);   end
                default:
                begin
                    if ($urandom_range(0, 6) == 0)
                    begin
                        v = DIV_W'($urandom_range(0, 511));
                        h = DIV_W'($urandom_range(0, 511));
                    end
                    else
                    begin
                        v = DIV_W'($urandom_range(3, 6));
                        h = DIV_W'($urandom_range(3, 6));
                    end
                end
            endcase
            set_divisions(v, h);
            // mostly clean walks; the odd restart breaks a mesh in the middle
            repeat (PHASE_ITEMS) send_request($urandom_range(0, 24) == 0);
        end

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d triangles under %0d division settings:",
                 sb.checked, settings_used);
        $display("%0d whole meshes, %0d restarts.", sb.meshes, restarts_sent);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
